/* rtl/tea_pkg.sv */
// Shared types, constants and the round mixing function for the TEA engine.
package tea_pkg;

    // Cipher geometry.
    localparam int ROUNDS    = 32;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 8;

    // Round constant and the starting sum for decryption.
    localparam logic [WORD_W-1:0] DELTA   = 32'h9e37_79b9;
    localparam logic [WORD_W-1:0] DEC_SUM = WORD_W'(64'(DELTA) * 64'(ROUNDS));

    // Key values after reset.
    localparam logic [WORD_W-1:0] KEY0_RESET = 32'h5a5a_dead;
    localparam logic [WORD_W-1:0] KEY1_RESET = 32'h5a5a_dead;
    localparam logic [WORD_W-1:0] KEY2_RESET = 32'h55aa_dead;
    localparam logic [WORD_W-1:0] KEY3_RESET = 32'h55aa_dead;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 8'd3;

    // Command codes.
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // The 128-bit key as four words.
    typedef struct packed {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
    } key_t;

    // Payload that walks down the chain of round cells.
    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] l;
        logic [WORD_W-1:0] r;
        logic [WORD_W-1:0] sum;
    } pipe_t;

    // TEA mixing function of one half round.
    function automatic logic [WORD_W-1:0] tea_mix(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        tea_mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

endpackage

/* rtl/tea_round.sv */
// One TEA round cell: two registered half rounds, forward or inverse.
module tea_round
    import tea_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  key_t  key,
    input  logic  in_valid,
    input  pipe_t in_data,
    output logic  out_valid,
    output pipe_t out_data
);

    logic  half_valid_reg;
    pipe_t half_data_reg;
    pipe_t half_data_next;
    logic  full_valid_reg;
    pipe_t full_data_reg;
    pipe_t full_data_next;

    // First half: encrypt updates the left word, decrypt undoes the right word.
    always_comb
    begin
        half_data_next = in_data;
        if (in_data.cmd == CMD_DECRYPT)
        begin
            half_data_next.r = in_data.r - tea_mix(in_data.l, in_data.sum, key.k2, key.k3);
        end
        else
        begin
            half_data_next.l = in_data.l + tea_mix(in_data.r, in_data.sum, key.k0, key.k1);
        end
    end

    // Second half: the other word, then step the running sum for the next round.
    always_comb
    begin
        full_data_next = half_data_reg;
        if (half_data_reg.cmd == CMD_DECRYPT)
        begin
            full_data_next.l = half_data_reg.l
                - tea_mix(half_data_reg.r, half_data_reg.sum, key.k0, key.k1);
            full_data_next.sum = half_data_reg.sum - DELTA;
        end
        else
        begin
            full_data_next.r = half_data_reg.r
                + tea_mix(half_data_reg.l, half_data_reg.sum, key.k2, key.k3);
            full_data_next.sum = half_data_reg.sum + DELTA;
        end
    end

    // Valid bits are reset; payload registers simply follow.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_valid_reg <= 1'b0;
            full_valid_reg <= 1'b0;
        end
        else
        begin
            half_valid_reg <= in_valid;
            full_valid_reg <= half_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        half_data_reg <= half_data_next;
        full_data_reg <= full_data_next;
    end

    assign out_valid = full_valid_reg;
    assign out_data  = full_data_reg;

endmodule

/* rtl/tea_block_cipher.sv */
// Top level of the TEA engine: key registers and the chain of round cells.
// A block passes both registered halves of each round cell in turn before done rises.
// Throughput: one block per cycle; busy stays low, each round cell has two stages.
// The result is shown for one cycle with done high; the receiver cannot stall.
// Reset empties the round chain and restores the built-in key words.
module tea_block_cipher
    import tea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cmd,
    input  logic [WORD_W-1:0]    first_word,
    input  logic [WORD_W-1:0]    second_word,
    output logic                 done,
    output logic [WORD_W-1:0]    out_first_word,
    output logic [WORD_W-1:0]    out_second_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    key_t  key_reg;
    key_t  key_next;
    logic  accept;
    pipe_t head_data;
    logic  chain_valid [ROUNDS+1];
    pipe_t chain_data  [ROUNDS+1];

    // The chain never blocks, so requests and key writes are always taken.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Key register writes; unknown indexes are dropped.
    always_comb
    begin
        key_next = key_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEY0: key_next.k0 = cfg_data;
                REG_KEY1: key_next.k1 = cfg_data;
                REG_KEY2: key_next.k2 = cfg_data;
                REG_KEY3: key_next.k3 = cfg_data;
                default:  key_next    = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg.k0 <= KEY0_RESET;
            key_reg.k1 <= KEY1_RESET;
            key_reg.k2 <= KEY2_RESET;
            key_reg.k3 <= KEY3_RESET;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    // Load the block and the starting sum for the selected direction.
    always_comb
    begin
        head_data.cmd = cmd;
        head_data.l   = first_word;
        head_data.r   = second_word;
        head_data.sum = (cmd == CMD_DECRYPT) ? DEC_SUM : DELTA;
    end

    assign chain_valid[0] = accept;
    assign chain_data[0]  = head_data;

    // One cell per round, each feeding its neighbor every cycle.
    for (genvar i = 0; i < ROUNDS; i++)
    begin : g_round
        tea_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .key       (key_reg),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // The last cell's registers drive the result ports directly.
    assign done            = chain_valid[ROUNDS];
    assign out_first_word  = chain_data[ROUNDS].l;
    assign out_second_word = chain_data[ROUNDS].r;

endmodule
